// ===== design/btlpm_pkg.sv =====
`default_nettype none
package btlpm_pkg;

   localparam int NODE_COUNT = 1024;
   localparam int NODE_BITS  = $clog2(NODE_COUNT);
   localparam int USED_BITS  = NODE_BITS + 1;
   localparam int ADDR_BITS  = 32;
   localparam int IDX_BITS   = $clog2(ADDR_BITS);
   localparam int LEN_BITS   = 6;
   localparam int GATE_BITS  = 8;

   localparam logic [NODE_BITS-1:0] NO_CHILD = '0;

   typedef enum logic {
      ACT_INSERT = 1'b0,
      ACT_LOOKUP = 1'b1
   } action_type;

   typedef struct packed {
      logic                 action;
      logic [ADDR_BITS-1:0] address;
      logic [LEN_BITS-1:0]  prefix_len;
      logic [GATE_BITS-1:0] gate_id;
   } req_type;

   typedef struct packed {
      logic                 status;
      logic                 matched;
      logic [LEN_BITS-1:0]  match_len;
      logic [GATE_BITS-1:0] match_gate;
   } rsp_type;

   typedef struct packed {
      logic [1:0][NODE_BITS-1:0] child;
      logic [GATE_BITS-1:0]      gate;
   } node_type;

   localparam int NODE_WIDTH = $bits(node_type);

   typedef struct packed {
      logic                 bit_sel;
      logic [NODE_BITS-1:0] child;
      logic                 advance;
      logic                 gate_hit;
   } step_type;

   // address bit taken at a given trie depth, top bit first
   function automatic logic addr_bit(input logic [ADDR_BITS-1:0] address,
                                     input logic [LEN_BITS-1:0]  depth);
      logic [IDX_BITS-1:0] idx;
      idx = IDX_BITS'(ADDR_BITS - 1) - depth[IDX_BITS-1:0];
      return address[idx];
   endfunction

endpackage
`default_nettype wire

// ===== design/btlpm_ram.sv =====
`default_nettype none
module btlpm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule
`default_nettype wire

// ===== design/btlpm_step.sv =====
`default_nettype none
module btlpm_step
   import btlpm_pkg::*;
(
   input  wire node_type             cur,
   input  wire logic [ADDR_BITS-1:0] address,
   input  wire logic [LEN_BITS-1:0]  depth,
   input  wire logic [LEN_BITS-1:0]  limit,
   output      step_type             step
);

   always_comb begin
      step.bit_sel  = addr_bit(address, depth);
      step.child    = cur.child[step.bit_sel];
      step.advance  = (depth < limit) && (step.child != NO_CHILD);
      // the root is never a gate
      step.gate_hit = (depth != '0) && (cur.gate != '0);
   end

endmodule
`default_nettype wire

// ===== design/binary_trie_longest_prefix_match.sv =====
`default_nettype none
// Channel   Ports                 Handshake
// request   start, busy, req_item accepted at an edge with start high, busy low
// response  rsp_valid, rsp_item   one-cycle strobe, always taken
//
// One trie level per node store read. A lookup walks down the trie and then
// answers with a registered response. An insert walks the existing path,
// checks room, links the first new node and then writes one new node per
// cycle; the walk stops where the new nodes begin. The root lives in
// flip-flops, so reset needs no clearing pass. The response is never stalled.
module binary_trie_longest_prefix_match
   import btlpm_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output      logic    busy,
   input  wire req_type req_item,
   output      logic    rsp_valid,
   output      rsp_type rsp_item
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WALK,
      ST_CHECK,
      ST_LINK,
      ST_ALLOC
   } state_type;

   state_type                  state_ff, state_in;
   logic                       action_ff, action_in;
   logic [ADDR_BITS-1:0]       address_ff, address_in;
   logic [LEN_BITS-1:0]        limit_ff, limit_in;
   logic [GATE_BITS-1:0]       gate_ff, gate_in;
   logic [NODE_BITS-1:0]       node_ff, node_in;
   logic [LEN_BITS-1:0]        depth_ff, depth_in;
   node_type                   held_ff, held_in;
   logic [USED_BITS-1:0]       used_ff, used_in;
   logic [1:0][NODE_BITS-1:0]  root_ff, root_in;
   logic                       hit_ff, hit_in;
   logic [LEN_BITS-1:0]        best_len_ff, best_len_in;
   logic [GATE_BITS-1:0]       best_gate_ff, best_gate_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   rsp_type                    rsp_ff, rsp_in;

   logic                       ram_wr_en;
   logic [NODE_BITS-1:0]       ram_wr_addr;
   node_type                   ram_wr_data;
   logic                       ram_rd_en;
   logic [NODE_BITS-1:0]       ram_rd_addr;
   logic [NODE_WIDTH-1:0]      ram_rd_data;

   node_type                   cur;
   step_type                   step;
   logic [LEN_BITS-1:0]        clamp_len;
   logic [LEN_BITS-1:0]        need;
   logic [USED_BITS:0]         room_sum;
   logic [LEN_BITS-1:0]        next_depth;
   logic                       link_bit;

   btlpm_ram #(
      .WIDTH (NODE_WIDTH),
      .DEPTH (NODE_COUNT)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      if (depth_ff == '0) begin
         cur.child = root_ff;
         cur.gate  = '0;
      end else begin
         cur = node_type'(ram_rd_data);
      end
   end

   btlpm_step u_step (
      .cur     (cur),
      .address (address_ff),
      .depth   (depth_ff),
      .limit   (limit_ff),
      .step    (step)
   );

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   assign clamp_len  = (req_item.prefix_len > LEN_BITS'(ADDR_BITS)) ?
                       LEN_BITS'(ADDR_BITS) : req_item.prefix_len;
   assign need       = limit_ff - depth_ff;
   assign room_sum   = (USED_BITS+1)'(used_ff) + (USED_BITS+1)'(need);
   assign next_depth = depth_ff + LEN_BITS'(1);
   assign link_bit   = addr_bit(address_ff, depth_ff);

   always_comb begin
      state_in     = state_ff;
      action_in    = action_ff;
      address_in   = address_ff;
      limit_in     = limit_ff;
      gate_in      = gate_ff;
      node_in      = node_ff;
      depth_in     = depth_ff;
      held_in      = held_ff;
      used_in      = used_ff;
      root_in      = root_ff;
      hit_in       = hit_ff;
      best_len_in  = best_len_ff;
      best_gate_in = best_gate_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = node_ff;
      ram_wr_data  = held_ff;
      ram_rd_en    = 1'b0;
      ram_rd_addr  = step.child;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               action_in    = req_item.action;
               address_in   = req_item.address;
               gate_in      = req_item.gate_id;
               limit_in     = (req_item.action == ACT_LOOKUP) ?
                              LEN_BITS'(ADDR_BITS) : clamp_len;
               node_in      = NO_CHILD;
               depth_in     = '0;
               hit_in       = 1'b0;
               best_len_in  = '0;
               best_gate_in = '0;
               if (req_item.action == ACT_INSERT && clamp_len == '0) begin
                  // empty prefix: nothing to mark
                  rsp_valid_in = 1'b1;
                  rsp_in       = '0;
               end else begin
                  state_in = ST_WALK;
               end
            end
         end
         ST_WALK: begin
            if (action_ff == ACT_LOOKUP && step.gate_hit) begin
               hit_in       = 1'b1;
               best_len_in  = depth_ff;
               best_gate_in = cur.gate;
            end
            if (step.advance) begin
               ram_rd_en = 1'b1;
               node_in   = step.child;
               depth_in  = next_depth;
            end else begin
               held_in = cur;
               if (action_ff == ACT_LOOKUP) begin
                  rsp_valid_in       = 1'b1;
                  rsp_in.status      = 1'b0;
                  rsp_in.matched     = hit_in;
                  rsp_in.match_len   = best_len_in;
                  rsp_in.match_gate  = best_gate_in;
                  state_in           = ST_IDLE;
               end else begin
                  state_in = ST_CHECK;
               end
            end
         end
         ST_CHECK: begin
            rsp_in = '0;
            if (room_sum > (USED_BITS+1)'(NODE_COUNT)) begin
               rsp_valid_in  = 1'b1;
               rsp_in.status = 1'b1;
               state_in      = ST_IDLE;
            end else if (need == '0) begin
               // whole path exists: overwrite the gate on its last node
               ram_wr_en        = 1'b1;
               ram_wr_data.gate = gate_ff;
               rsp_valid_in     = 1'b1;
               state_in         = ST_IDLE;
            end else begin
               state_in = ST_LINK;
            end
         end
         ST_LINK: begin
            if (node_ff == NO_CHILD) begin
               root_in[link_bit] = used_ff[NODE_BITS-1:0];
            end else begin
               ram_wr_en                   = 1'b1;
               ram_wr_data.child[link_bit] = used_ff[NODE_BITS-1:0];
            end
            state_in = ST_ALLOC;
         end
         ST_ALLOC: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = used_ff[NODE_BITS-1:0];
            ram_wr_data = '0;
            if (next_depth < limit_ff) begin
               ram_wr_data.child[addr_bit(address_ff, next_depth)] =
                  used_ff[NODE_BITS-1:0] + NODE_BITS'(1);
            end else begin
               ram_wr_data.gate = gate_ff;
               rsp_valid_in     = 1'b1;
               rsp_in           = '0;
               state_in         = ST_IDLE;
            end
            used_in  = used_ff + USED_BITS'(1);
            depth_in = next_depth;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         used_ff      <= USED_BITS'(1);
         root_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         root_ff      <= root_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      action_ff    <= action_in;
      address_ff   <= address_in;
      limit_ff     <= limit_in;
      gate_ff      <= gate_in;
      node_ff      <= node_in;
      depth_ff     <= depth_in;
      held_ff      <= held_in;
      hit_ff       <= hit_in;
      best_len_ff  <= best_len_in;
      best_gate_ff <= best_gate_in;
      rsp_ff       <= rsp_in;
   end

   // every accepted transaction keeps the block busy or answers next cycle
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy || rsp_valid))
      else $error("accepted transaction neither busy nor answered");

   // a response only goes out once the block is free again
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("response strobe while still busy");

   assert property (@(posedge clock) disable iff (reset)
      used_ff <= USED_BITS'(NODE_COUNT))
      else $error("node store allocated past its size");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_item.matched) |-> (rsp_item.match_len == '0 &&
                                            rsp_item.match_gate == '0))
      else $error("miss reported with a length or gate");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ALLOC) |-> (depth_ff < limit_ff))
      else $error("allocation past the prefix depth");

endmodule
`default_nettype wire

// ===== test/testbench.sv =====
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import btlpm_pkg::*;

   localparam int RANDOM_TXNS    = 750;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int TAIL_CYCLES    = 100;

   typedef struct {
      req_type item;
      bit      drain_first;
   } pending_txn;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_item;
   logic    rsp_valid;
   rsp_type rsp_item;

   binary_trie_longest_prefix_match uut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

   // routing table mirror
   logic [NODE_BITS-1:0] trie_child [NODE_COUNT][2];
   logic [GATE_BITS-1:0] trie_gate [NODE_COUNT];
   int unsigned          trie_used;

   pending_txn  txn_queue[$];
   rsp_type     route_answers[$];
   logic [31:0] route_seen[$];

   int total_txns;
   int sent_count;
   int taken_count;
   int idle_cycles;
   int mismatch_count;
   int insert_count;
   int lookup_count;
   int full_count;
   int hit_count;
   int result_count;
   bit holding;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic void clear_routes();
      for (int i = 0; i < NODE_COUNT; i++) begin
         trie_child[i][0] = NO_CHILD;
         trie_child[i][1] = NO_CHILD;
         trie_gate[i]     = '0;
      end
      trie_used = 1;
   endfunction

   // apply one transaction to the mirror and return the answer it must produce
   function automatic rsp_type apply_route_txn(req_type r);
      rsp_type     ans;
      int unsigned len;
      int unsigned depth;
      int unsigned node;
      int unsigned nxt;
      bit          walking;
      ans = '0;
      node = 0;
      depth = 0;
      walking = 1'b1;
      if (r.action == ACT_LOOKUP) begin
         lookup_count++;
         while (walking && depth < ADDR_BITS) begin
            nxt = trie_child[node][r.address[ADDR_BITS-1-depth]];
            if (nxt == NO_CHILD) begin
               walking = 1'b0;
            end else begin
               node = nxt;
               depth++;
               if (trie_gate[node] != 0) begin
                  ans.matched    = 1'b1;
                  ans.match_len  = LEN_BITS'(depth);
                  ans.match_gate = trie_gate[node];
               end
            end
         end
         if (ans.matched) hit_count++;
      end else begin
         insert_count++;
         len = (r.prefix_len > ADDR_BITS) ? ADDR_BITS : r.prefix_len;
         if (len != 0) begin
            while (walking && depth < len) begin
               nxt = trie_child[node][r.address[ADDR_BITS-1-depth]];
               if (nxt == NO_CHILD) begin
                  walking = 1'b0;
               end else begin
                  node = nxt;
                  depth++;
               end
            end
            if (trie_used + (len - depth) > NODE_COUNT) begin
               ans.status = 1'b1;
               full_count++;
            end else begin
               while (depth < len) begin
                  nxt = trie_used;
                  trie_used++;
                  trie_child[nxt][0] = NO_CHILD;
                  trie_child[nxt][1] = NO_CHILD;
                  trie_gate[nxt]     = '0;
                  trie_child[node][r.address[ADDR_BITS-1-depth]] = NODE_BITS'(nxt);
                  node = nxt;
                  depth++;
               end
               trie_gate[node] = r.gate_id;
            end
         end
      end
      return ans;
   endfunction

   function automatic req_type make_req(action_type act, logic [ADDR_BITS-1:0] address,
                                        logic [LEN_BITS-1:0] len, logic [GATE_BITS-1:0] gate);
      req_type r;
      r.action     = act;
      r.address    = address;
      r.prefix_len = len;
      r.gate_id    = gate;
      return r;
   endfunction

   task automatic queue_txn(input req_type r, input bit drain_first);
      pending_txn p;
      p.item        = r;
      p.drain_first = drain_first;
      txn_queue.push_back(p);
   endtask

   task automatic build_stimulus();
      logic [ADDR_BITS-1:0] bases[6];
      logic [ADDR_BITS-1:0] address;
      logic [LEN_BITS-1:0]  len;
      logic [GATE_BITS-1:0] gate;
      req_type              r;
      int                   pick;

      // empty table, then zero-length prefix
      queue_txn(make_req(ACT_LOOKUP, 32'h0000_0000, '0, '0), 1'b0);
      queue_txn(make_req(ACT_LOOKUP, 32'hFFFF_FFFF, '1, '1), 1'b0);
      queue_txn(make_req(ACT_INSERT, 32'hFFFF_FFFF, 6'd0, 8'd9), 1'b0);
      queue_txn(make_req(ACT_LOOKUP, 32'hFFFF_FFFF, '0, '0), 1'b0);
      queue_txn(make_req(ACT_INSERT, 32'h8000_0000, 6'd1, 8'd1), 1'b0);
      queue_txn(make_req(ACT_INSERT, 32'hFFFF_FFFF, 6'd32, 8'd255), 1'b0);
      queue_txn(make_req(ACT_LOOKUP, 32'hFFFF_FFFF, '0, '0), 1'b0);
      queue_txn(make_req(ACT_LOOKUP, 32'h8000_0000, '0, '0), 1'b0);
      queue_txn(make_req(ACT_INSERT, 32'h0000_0000, 6'd32, 8'd3), 1'b1);
      queue_txn(make_req(ACT_LOOKUP, 32'h0000_0000, '0, '0), 1'b0);
      // nested prefixes, overwrite, then clear with gate zero
      queue_txn(make_req(ACT_INSERT, 32'hC0A8_0000, 6'd16, 8'd20), 1'b0);
      queue_txn(make_req(ACT_INSERT, 32'hC0A8_0100, 6'd24, 8'd21), 1'b0);
      queue_txn(make_req(ACT_LOOKUP, 32'hC0A8_0105, '0, '0), 1'b0);
      queue_txn(make_req(ACT_LOOKUP, 32'hC0A9_0000, '0, '0), 1'b0);
      queue_txn(make_req(ACT_INSERT, 32'hC0A8_0100, 6'd24, 8'd22), 1'b0);
      queue_txn(make_req(ACT_LOOKUP, 32'hC0A8_01FF, '0, '0), 1'b0);
      queue_txn(make_req(ACT_INSERT, 32'hC0A8_0100, 6'd24, 8'd0), 1'b0);
      queue_txn(make_req(ACT_LOOKUP, 32'hC0A8_01FF, '0, '0), 1'b0);
      // lengths beyond the address width clamp to a full-length prefix
      queue_txn(make_req(ACT_INSERT, 32'h1234_5678, 6'd63, 8'hAA), 1'b0);
      queue_txn(make_req(ACT_LOOKUP, 32'h1234_5678, '0, '0), 1'b0);
      queue_txn(make_req(ACT_INSERT, 32'h1234_5600, 6'd40, 8'h55), 1'b0);
      queue_txn(make_req(ACT_LOOKUP, 32'h1234_5600, '0, '0), 1'b0);
      queue_txn(make_req(ACT_LOOKUP, 32'h1234_5679, '0, '0), 1'b0);
      route_seen.push_back(32'hC0A8_0100);
      route_seen.push_back(32'h1234_5678);

      foreach (bases[i]) bases[i] = $urandom();

      // clustered prefixes share paths, so lookups walk deep before the table fills
      for (int i = 0; i < RANDOM_TXNS; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 45) begin
            if ($urandom_range(0, 9) < 7)
               address = bases[$urandom_range(0, 5)] ^ ($urandom() >> $urandom_range(4, 32));
            else
               address = $urandom();
            pick = $urandom_range(0, 99);
            if (pick < 8)
               len = 6'd0;
            else if (pick < 15)
               len = LEN_BITS'($urandom_range(33, 63));
            else
               len = LEN_BITS'($urandom_range(1, 32));
            gate = ($urandom_range(0, 19) == 0) ? 8'd0 : GATE_BITS'($urandom_range(1, 255));
            r = make_req(ACT_INSERT, address, len, gate);
            route_seen.push_back(address);
         end else begin
            if ($urandom_range(0, 3) != 0)
               address = route_seen[$urandom_range(0, route_seen.size() - 1)]
                         ^ ($urandom() >> $urandom_range(0, 32));
            else
               address = $urandom();
            r = make_req(ACT_LOOKUP, address, LEN_BITS'($urandom()), GATE_BITS'($urandom()));
         end
         queue_txn(r, $urandom_range(0, 49) == 0);
      end
      total_txns = txn_queue.size();
   endtask

   function automatic bit sender_idles();
      if (sent_count < total_txns / 3)
         return $urandom_range(0, 99) < 12;
      else if (sent_count < 2 * total_txns / 3)
         return $urandom_range(0, 99) < 60;
      return 1'b0;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("[%0t] result %0d: %s got %0d, want %0d", $realtime, result_count, what, got,
               want);
      mismatch_count++;
   endtask

   task automatic check_result(input rsp_type got);
      rsp_type want;
      if (route_answers.size() == 0) begin
         report_mismatch("unexpected result, status", got.status, 0);
      end else begin
         want = route_answers.pop_front();
         if (got.status !== want.status)
            report_mismatch("status", got.status, want.status);
         if (got.matched !== want.matched)
            report_mismatch("matched", got.matched, want.matched);
         if (got.match_len !== want.match_len)
            report_mismatch("match_len", got.match_len, want.match_len);
         if (got.match_gate !== want.match_gate)
            report_mismatch("match_gate", got.match_gate, want.match_gate);
      end
      result_count++;
   endtask

   // driver: hold a transaction until it is taken, then advance
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         holding = start && taken_count == sent_count;
         if (start && taken_count != sent_count) begin
            sent_count = sent_count + 1;
            void'(txn_queue.pop_front());
         end
         if (!holding) begin
            if (txn_queue.size() != 0 && !(txn_queue[0].drain_first && route_answers.size() != 0)
                && !sender_idles()) begin
               start    <= 1'b1;
               req_item <= txn_queue[0].item;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // monitor: check results, record accepted transactions, watch for a hang
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid)
            check_result(rsp_item);
         if (start && !busy) begin
            route_answers.push_back(apply_route_txn(req_item));
            taken_count = taken_count + 1;
         end
         if (rsp_valid || (start && !busy))
            idle_cycles = 0;
         else
            idle_cycles = idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog expired after %0d idle cycles, %0d of %0d transactions taken",
                     idle_cycles, taken_count, total_txns);
            $display("Mismatches found");
            $finish;
         end
      end
   end

   initial begin
      reset          = 1'b1;
      start          = 1'b0;
      req_item       = '0;
      sent_count     = 0;
      taken_count    = 0;
      idle_cycles    = 0;
      mismatch_count = 0;
      insert_count   = 0;
      lookup_count   = 0;
      full_count     = 0;
      hit_count      = 0;
      result_count   = 0;
      clear_routes();
      build_stimulus();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      while (taken_count < total_txns || route_answers.size() != 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Covered %0d inserts (%0d refused on a full table, %0d of %0d nodes used)",
               insert_count, full_count, trie_used, NODE_COUNT);
      $display("and %0d lookups (%0d matched); %0d results checked", lookup_count, hit_count,
               result_count);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
